@@ sv/block_compare_checksum_defines.svh @@
// Assertion helpers for the design files that check their own logic.
`ifndef BLOCK_COMPARE_CHECKSUM_DEFINES_SVH
`define BLOCK_COMPARE_CHECKSUM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bcc_pkg.sv @@
package bcc_pkg;

  localparam logic [7:0] BCC_MIN_LEN       = 8'd10;
  localparam logic [7:0] BCC_MAX_BLOCK_LEN = 8'd255;
  localparam logic [7:0] BCC_RESET_LEN     = 8'd200;
  localparam logic [9:0] BCC_RESET_MOD     = 10'd0;
  localparam int unsigned BCC_QUEUE_DEPTH  = 4;
  localparam int unsigned BCC_CHK_W        = 16;

  // Register indexes on the configuration port.
  localparam logic REG_BLOCK_LENGTH  = 1'b0;
  localparam logic REG_CHECK_MODULUS = 1'b1;

  // Report kinds.
  localparam logic [1:0] KIND_MISMATCH = 2'd0;
  localparam logic [1:0] KIND_BLOCK    = 2'd1;
  localparam logic [1:0] KIND_TOTALS   = 2'd2;

  typedef struct packed {
    logic [7:0] block_length;
    logic [9:0] check_modulus;
  } bcc_cfg_t;

  // One classified item, as handed from the front end to the back end.
  typedef struct packed {
    logic                 mis;
    logic                 blk_bad;
    logic                 last;
    logic [23:0]          blk_num;
    logic [7:0]           pos;
    logic [7:0]           good_byte;
    logic [7:0]           suspect_byte;
    logic [BCC_CHK_W-1:0] good_chk;
    logic [BCC_CHK_W-1:0] suspect_chk;
    logic [9:0]           modulus;
    logic [31:0]          old_bytes;
    logic [31:0]          new_bytes;
    logic [23:0]          old_blocks;
    logic [23:0]          new_blocks;
  } bcc_job_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] blk_num;
    logic [7:0]  pos;
    logic [15:0] good_val;
    logic [15:0] suspect_val;
    logic [31:0] bytes_tot;
    logic [23:0] blocks_tot;
    logic        last;
  } bcc_res_t;

endpackage

@@ sv/block_compare_checksum.sv @@
// Block compare with per-block check values. Byte pairs (good, suspect) are
// pushed in one per clock while full is low; they are grouped into blocks of
// block_length pairs (values below 10 act as 10), and a pair with
// end_of_data set closes the current block early. Each differing position
// gives a mismatch item; each block that closes with mismatches gives an item
// with the two XOR parities (check_modulus 0) or the two byte sums reduced
// modulo check_modulus; end of data gives a totals item and restarts all
// counting from block 1. Block numbers and totals saturate. Items leave in
// order through a queue-style port, and last_report marks the final item
// that one input pair caused. The front end takes one pair every cycle as
// long as its job queue (QUEUE_DEPTH entries) has room; a pair that causes no
// report never enters the queue. The back end fetches a job only when it is
// through with the last one, then delivers its items one by one as the
// result register frees; a bad block report first passes a dispatch step,
// and with a nonzero modulus it waits for the shared remainder unit, which
// retires one dividend bit per cycle for both sums. Pairs are therefore
// taken at one per cycle in clean stretches and at the back end's pace once
// the queue is full. There is no clearing pass after reset. The configuration
// registers sit at byte addresses 0 (block_length) and 4 (check_modulus) and
// should be written only while no work is in flight.
`include "block_compare_checksum_defines.svh"

module block_compare_checksum #(
  parameter int unsigned QUEUE_DEPTH = bcc_pkg::BCC_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_good_byte,
  input  logic [7:0]  in_suspect_byte,
  input  logic        in_end_of_data,
  // Result channel.
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_report_kind,
  output logic [23:0] out_block_number,
  output logic [7:0]  out_byte_position,
  output logic [15:0] out_good_value,
  output logic [15:0] out_suspect_value,
  output logic [31:0] out_bad_byte_total,
  output logic [23:0] out_bad_block_total,
  output logic        out_last_report,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bcc_pkg::*;

  logic [7:0] blen_r;
  logic [9:0] cmod_r;
  bcc_cfg_t   cfg;
  logic       cfg_wr;
  logic       reg_sel;

  bcc_job_t   fe_job;
  logic       q_wr;
  logic       q_full;
  bcc_job_t   q_head;
  logic       q_rd;
  logic       q_empty;
  logic       out_valid;
  bcc_res_t   res;

  // Register file: the word address alone selects the register.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blen_r <= BCC_RESET_LEN;
      cmod_r <= BCC_RESET_MOD;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BLOCK_LENGTH:  blen_r <= pwdata[7:0];
        REG_CHECK_MODULUS: cmod_r <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BLOCK_LENGTH:  prdata = {24'd0, blen_r};
      REG_CHECK_MODULUS: prdata = {22'd0, cmod_r};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg.block_length  = blen_r;
  assign cfg.check_modulus = cmod_r;

  // The front end updates the running block state and classifies each pair.
  bcc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .push         (push),
    .good_byte    (in_good_byte),
    .suspect_byte (in_suspect_byte),
    .end_of_data  (in_end_of_data),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .job          (fe_job)
  );

  assign full = q_full;

  // Jobs wait here so that a slow block report does not stall the input.
  bcc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (fe_job),
    .rd      (q_rd),
    .rd_data (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // The back end expands each job into its items and computes the remainders.
  bcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_rd      (q_rd),
    .pop       (pop),
    .out_valid (out_valid),
    .res       (res)
  );

  assign empty               = ~out_valid;
  assign out_report_kind     = res.kind;
  assign out_block_number    = res.blk_num;
  assign out_byte_position   = res.pos;
  assign out_good_value      = res.good_val;
  assign out_suspect_value   = res.suspect_val;
  assign out_bad_byte_total  = res.bytes_tot;
  assign out_bad_block_total = res.blocks_tot;
  assign out_last_report     = res.last;

  // A job must never be written while the queue is full.
  `BCC_ASSERT_SAME(a_no_write_when_full, clk, rst_n, q_full, !q_wr, "job written into a full queue")
  // A totals item always ends the items of its input pair.
  `BCC_ASSERT_SAME(a_totals_is_last, clk, rst_n, !empty && out_report_kind == KIND_TOTALS, out_last_report, "totals item not marked last")
  // A mismatch item carries two different bytes.
  `BCC_ASSERT_SAME(a_mismatch_differs, clk, rst_n, !empty && out_report_kind == KIND_MISMATCH, out_good_value != out_suspect_value, "mismatch item with equal bytes")

endmodule

@@ sv/bcc_front.sv @@
module bcc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  bcc_pkg::bcc_cfg_t cfg,
  input  logic              push,
  input  logic [7:0]        good_byte,
  input  logic [7:0]        suspect_byte,
  input  logic              end_of_data,
  input  logic              q_full,
  output logic              q_wr,
  output bcc_pkg::bcc_job_t job
);
  import bcc_pkg::*;

  logic [7:0]           pos_r;
  logic [23:0]          blocks_seen_r;
  logic [7:0]           blk_mis_r;
  logic [BCC_CHK_W-1:0] gchk_r;
  logic [BCC_CHK_W-1:0] schk_r;
  logic [31:0]          tot_bytes_r;
  logic [23:0]          tot_blocks_r;

  logic                 accept;
  logic                 start;
  logic                 mm;
  logic                 close;
  logic                 blk_bad;
  logic [7:0]           eff_len;
  logic [7:0]           pos_nxt;
  logic [23:0]          bs;
  logic [7:0]           mis0;
  logic [7:0]           mis1;
  logic [BCC_CHK_W-1:0] gc0;
  logic [BCC_CHK_W-1:0] sc0;
  logic [BCC_CHK_W-1:0] gc1;
  logic [BCC_CHK_W-1:0] sc1;
  logic [32:0]          bytes_sum;
  logic [31:0]          bytes_nxt;
  logic [23:0]          blocks_nxt;

  assign accept = push & ~q_full;

  always_comb begin
    eff_len = cfg.block_length;
    if (eff_len < BCC_MIN_LEN) begin
      eff_len = BCC_MIN_LEN;
    end
    if (eff_len > BCC_MAX_BLOCK_LEN) begin
      eff_len = BCC_MAX_BLOCK_LEN;
    end

    // A new block starts when the position is back at zero.
    start = (pos_r == 8'd0);
    bs    = (start && blocks_seen_r != 24'hFF_FFFF) ? blocks_seen_r + 24'd1 : blocks_seen_r;
    mis0  = start ? 8'd0 : blk_mis_r;
    gc0   = start ? '0 : gchk_r;
    sc0   = start ? '0 : schk_r;

    mm   = (good_byte != suspect_byte);
    mis1 = (mm && mis0 != 8'hFF) ? mis0 + 8'd1 : mis0;

    if (cfg.check_modulus == 10'd0) begin
      gc1 = gc0 ^ {{(BCC_CHK_W-8){1'b0}}, good_byte};
      sc1 = sc0 ^ {{(BCC_CHK_W-8){1'b0}}, suspect_byte};
    end else begin
      gc1 = gc0 + {{(BCC_CHK_W-8){1'b0}}, good_byte};
      sc1 = sc0 + {{(BCC_CHK_W-8){1'b0}}, suspect_byte};
    end

    pos_nxt = pos_r + 8'd1;
    close   = (pos_nxt >= eff_len) | end_of_data;
    blk_bad = close & (mis1 != 8'd0);

    bytes_sum  = {1'b0, tot_bytes_r} + {25'd0, mis1};
    bytes_nxt  = tot_bytes_r;
    blocks_nxt = tot_blocks_r;
    if (blk_bad) begin
      bytes_nxt  = bytes_sum[32] ? 32'hFFFF_FFFF : bytes_sum[31:0];
      blocks_nxt = (tot_blocks_r != 24'hFF_FFFF) ? tot_blocks_r + 24'd1 : tot_blocks_r;
    end

    job.mis          = mm;
    job.blk_bad      = blk_bad;
    job.last         = end_of_data;
    job.blk_num      = bs;
    job.pos          = pos_r;
    job.good_byte    = good_byte;
    job.suspect_byte = suspect_byte;
    job.good_chk     = gc1;
    job.suspect_chk  = sc1;
    job.modulus      = cfg.check_modulus;
    job.old_bytes    = tot_bytes_r;
    job.new_bytes    = bytes_nxt;
    job.old_blocks   = tot_blocks_r;
    job.new_blocks   = blocks_nxt;
  end

  // Items that cause no report leave the queue alone.
  assign q_wr = accept & (mm | blk_bad | end_of_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      blocks_seen_r <= '0;
      blk_mis_r     <= '0;
      gchk_r        <= '0;
      schk_r        <= '0;
      tot_bytes_r   <= '0;
      tot_blocks_r  <= '0;
    end else if (accept) begin
      if (end_of_data) begin
        pos_r         <= '0;
        blocks_seen_r <= '0;
        blk_mis_r     <= '0;
        gchk_r        <= '0;
        schk_r        <= '0;
        tot_bytes_r   <= '0;
        tot_blocks_r  <= '0;
      end else begin
        blocks_seen_r <= bs;
        gchk_r        <= gc1;
        schk_r        <= sc1;
        tot_bytes_r   <= bytes_nxt;
        tot_blocks_r  <= blocks_nxt;
        if (close) begin
          pos_r     <= '0;
          blk_mis_r <= '0;
        end else begin
          pos_r     <= pos_nxt;
          blk_mis_r <= mis1;
        end
      end
    end
  end

endmodule

@@ sv/bcc_fifo.sv @@
module bcc_fifo #(
  parameter int unsigned DEPTH = bcc_pkg::BCC_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  bcc_pkg::bcc_job_t wr_data,
  input  logic              rd,
  output bcc_pkg::bcc_job_t rd_data,
  output logic              full,
  output logic              empty
);
  import bcc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  bcc_job_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr & ~full;
  assign do_rd   = rd & ~empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/bcc_div.sv @@
module bcc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bcc_pkg::BCC_CHK_W-1:0] dvd_a,
  input  logic [bcc_pkg::BCC_CHK_W-1:0] dvd_b,
  input  logic [9:0]                    divisor,
  output logic                          done,
  output logic [9:0]                    rem_a,
  output logic [9:0]                    rem_b
);
  import bcc_pkg::*;

  localparam int unsigned CNT_W = $clog2(BCC_CHK_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(BCC_CHK_W - 1);

  logic                 busy_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [BCC_CHK_W-1:0] dvd_a_r;
  logic [BCC_CHK_W-1:0] dvd_b_r;
  logic [9:0]           rem_a_r;
  logic [9:0]           rem_b_r;
  logic [9:0]           div_r;
  logic [10:0]          try_a;
  logic [10:0]          try_b;
  logic [9:0]           rem_a_nxt;
  logic [9:0]           rem_b_nxt;

  // Restoring shift-subtract, one dividend bit per cycle for both streams.
  always_comb begin
    try_a     = {rem_a_r, dvd_a_r[BCC_CHK_W-1]};
    try_b     = {rem_b_r, dvd_b_r[BCC_CHK_W-1]};
    rem_a_nxt = (try_a >= {1'b0, div_r}) ? 10'(try_a - {1'b0, div_r}) : try_a[9:0];
    rem_b_nxt = (try_b >= {1'b0, div_r}) ? 10'(try_b - {1'b0, div_r}) : try_b[9:0];
  end

  assign done  = busy_r & (cnt_r == LAST_STEP);
  assign rem_a = rem_a_r;
  assign rem_b = rem_b_r;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_a_r <= dvd_a;
      dvd_b_r <= dvd_b;
      div_r   <= divisor;
      rem_a_r <= '0;
      rem_b_r <= '0;
    end else if (busy_r) begin
      dvd_a_r <= {dvd_a_r[BCC_CHK_W-2:0], 1'b0};
      dvd_b_r <= {dvd_b_r[BCC_CHK_W-2:0], 1'b0};
      rem_a_r <= rem_a_nxt;
      rem_b_r <= rem_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      busy_r <= ~done;
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

endmodule

@@ sv/bcc_back.sv @@
module bcc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  bcc_pkg::bcc_job_t head,
  input  logic              q_empty,
  output logic              q_rd,
  input  logic              pop,
  output logic              out_valid,
  output bcc_pkg::bcc_res_t res
);
  import bcc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MIS  = 3'd1;
  localparam logic [2:0] S_DST  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_BLK  = 3'd4;
  localparam logic [2:0] S_TOT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  bcc_job_t   job_r;
  logic       out_v_r;
  logic       out_v_nxt;
  bcc_res_t   res_r;
  bcc_res_t   res_nxt;
  logic       load_ok;
  logic       load;
  logic       div_start;
  logic       div_done;
  logic [9:0] rem_a;
  logic [9:0] rem_b;

  function automatic logic [2:0] after_blk(input bcc_job_t j);
    return j.last ? S_TOT : S_IDLE;
  endfunction

  function automatic logic [2:0] after_mis(input bcc_job_t j);
    return j.blk_bad ? S_DST : after_blk(j);
  endfunction

  function automatic logic [2:0] first_step(input bcc_job_t j);
    return j.mis ? S_MIS : after_mis(j);
  endfunction

  bcc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dvd_a   (job_r.good_chk),
    .dvd_b   (job_r.suspect_chk),
    .divisor (job_r.modulus),
    .done    (div_done),
    .rem_a   (rem_a),
    .rem_b   (rem_b)
  );

  // The result register may be refilled in the cycle it is popped.
  assign load_ok = ~out_v_r | pop;

  always_comb begin
    state_nxt = state_r;
    q_rd      = 1'b0;
    load      = 1'b0;
    div_start = 1'b0;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_rd      = 1'b1;
          state_nxt = first_step(head);
        end
      end
      S_MIS: begin
        if (load_ok) begin
          load                = 1'b1;
          res_nxt.kind        = KIND_MISMATCH;
          res_nxt.blk_num     = job_r.blk_num;
          res_nxt.pos         = job_r.pos;
          res_nxt.good_val    = {8'd0, job_r.good_byte};
          res_nxt.suspect_val = {8'd0, job_r.suspect_byte};
          res_nxt.bytes_tot   = job_r.old_bytes;
          res_nxt.blocks_tot  = job_r.old_blocks;
          res_nxt.last        = ~job_r.blk_bad & ~job_r.last;
          state_nxt           = after_mis(job_r);
        end
      end
      S_DST: begin
        if (job_r.modulus == 10'd0) begin
          state_nxt = S_BLK;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_BLK;
        end
      end
      S_BLK: begin
        if (load_ok) begin
          load            = 1'b1;
          res_nxt.kind    = KIND_BLOCK;
          res_nxt.blk_num = job_r.blk_num;
          res_nxt.pos     = 8'd0;
          if (job_r.modulus == 10'd0) begin
            res_nxt.good_val    = job_r.good_chk;
            res_nxt.suspect_val = job_r.suspect_chk;
          end else begin
            res_nxt.good_val    = {6'd0, rem_a};
            res_nxt.suspect_val = {6'd0, rem_b};
          end
          res_nxt.bytes_tot  = job_r.new_bytes;
          res_nxt.blocks_tot = job_r.new_blocks;
          res_nxt.last       = ~job_r.last;
          state_nxt          = after_blk(job_r);
        end
      end
      S_TOT: begin
        if (load_ok) begin
          load                = 1'b1;
          res_nxt.kind        = KIND_TOTALS;
          res_nxt.blk_num     = job_r.blk_num;
          res_nxt.pos         = 8'd0;
          res_nxt.good_val    = 16'd0;
          res_nxt.suspect_val = 16'd0;
          res_nxt.bytes_tot   = job_r.new_bytes;
          res_nxt.blocks_tot  = job_r.new_blocks;
          res_nxt.last        = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load) begin
      out_v_nxt = 1'b1;
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      job_r <= head;
    end
    if (load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign res       = res_r;

endmodule

@@ tb/bcc_report_checker.sv @@
`timescale 1ns / 1ps

module bcc_report_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_good_byte,
  input  logic [7:0]  in_suspect_byte,
  input  logic        in_end_of_data,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  out_report_kind,
  input  logic [23:0] out_block_number,
  input  logic [7:0]  out_byte_position,
  input  logic [15:0] out_good_value,
  input  logic [15:0] out_suspect_value,
  input  logic [31:0] out_bad_byte_total,
  input  logic [23:0] out_bad_block_total,
  input  logic        out_last_report,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fault_count,
  output int          reports_pending,
  output int          pairs_taken,
  output int          reports_taken
);
  import bcc_pkg::*;

  logic [7:0]  len_reg;
  logic [9:0]  mod_reg;
  logic [7:0]  pos;
  logic [23:0] blk_num;
  logic [7:0]  blk_bad;
  logic [15:0] good_chk;
  logic [15:0] suspect_chk;
  logic [31:0] bad_bytes;
  logic [23:0] bad_blocks;
  bcc_res_t    expected_reports[$];
  int          faults;
  int          pairs;
  int          reports;

  function automatic bcc_res_t make_report(logic [1:0] kind, logic [7:0] at,
                                           logic [15:0] gv, logic [15:0] sv);
    make_report = '{kind: kind, blk_num: blk_num, pos: at, good_val: gv,
                    suspect_val: sv, bytes_tot: bad_bytes, blocks_tot: bad_blocks,
                    last: 1'b0};
  endfunction

  task automatic clear_tallies();
    pos         = '0;
    blk_num     = '0;
    blk_bad     = '0;
    good_chk    = '0;
    suspect_chk = '0;
    bad_bytes   = '0;
    bad_blocks  = '0;
  endtask

  // Works out every report that one byte pair causes, in delivery order.
  task automatic predict_pair(input logic [7:0] g, input logic [7:0] s, input logic eod);
    bcc_res_t    caused[$];
    logic [7:0]  eff_len;
    logic [15:0] gv;
    logic [15:0] sv;
    eff_len = (len_reg < BCC_MIN_LEN) ? BCC_MIN_LEN : len_reg;
    if (pos == 8'd0) begin
      if (blk_num != 24'hFF_FFFF) blk_num++;
      blk_bad     = '0;
      good_chk    = '0;
      suspect_chk = '0;
    end
    if (g != s) begin
      caused.push_back(make_report(KIND_MISMATCH, pos, {8'h00, g}, {8'h00, s}));
      if (blk_bad != 8'hFF) blk_bad++;
    end
    if (mod_reg == 10'd0) begin
      good_chk    = good_chk ^ {8'h00, g};
      suspect_chk = suspect_chk ^ {8'h00, s};
    end else begin
      good_chk    = good_chk + g;
      suspect_chk = suspect_chk + s;
    end
    pos++;
    if (pos >= eff_len || eod) begin
      if (blk_bad != 8'd0) begin
        if (bad_blocks != 24'hFF_FFFF) bad_blocks++;
        if (32'hFFFF_FFFF - bad_bytes < blk_bad) bad_bytes = 32'hFFFF_FFFF;
        else bad_bytes = bad_bytes + blk_bad;
        gv = good_chk;
        sv = suspect_chk;
        if (mod_reg != 10'd0) begin
          gv = good_chk % mod_reg;
          sv = suspect_chk % mod_reg;
        end
        caused.push_back(make_report(KIND_BLOCK, 8'd0, gv, sv));
      end
      pos     = '0;
      blk_bad = '0;
    end
    if (eod) begin
      caused.push_back(make_report(KIND_TOTALS, 8'd0, 16'd0, 16'd0));
      clear_tallies();
    end
    if (caused.size() > 0) caused[caused.size() - 1].last = 1'b1;
    foreach (caused[i]) expected_reports.push_back(caused[i]);
  endtask

  always @(posedge clk) begin
    bcc_res_t got;
    bcc_res_t want;
    if (!rst_n) begin
      len_reg = BCC_RESET_LEN;
      mod_reg = BCC_RESET_MOD;
      clear_tallies();
      expected_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_BLOCK_LENGTH:  len_reg = pwdata[7:0];
          REG_CHECK_MODULUS: mod_reg = pwdata[9:0];
        endcase
      end
      if (push && !full) begin
        pairs++;
        predict_pair(in_good_byte, in_suspect_byte, in_end_of_data);
      end
      if (pop && !empty) begin
        reports++;
        got = '{kind: out_report_kind, blk_num: out_block_number,
                pos: out_byte_position, good_val: out_good_value,
                suspect_val: out_suspect_value, bytes_tot: out_bad_byte_total,
                blocks_tot: out_bad_block_total, last: out_last_report};
        if (expected_reports.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("%0t: report of kind %0d from block %0d with none expected",
                     $realtime, got.kind, got.blk_num);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            faults++;
            if (faults <= 10)
              $display({"%0t: report %0d differs (expected/actual): kind %0d/%0d ",
                        "block %0d/%0d pos %0d/%0d good %0d/%0d suspect %0d/%0d ",
                        "bytes %0d/%0d blocks %0d/%0d last %0b/%0b"},
                       $realtime, reports, want.kind, got.kind, want.blk_num,
                       got.blk_num, want.pos, got.pos, want.good_val, got.good_val,
                       want.suspect_val, got.suspect_val, want.bytes_tot,
                       got.bytes_tot, want.blocks_tot, got.blocks_tot, want.last,
                       got.last);
          end
        end
      end
    end
    fault_count     <= faults;
    reports_pending <= expected_reports.size();
    pairs_taken     <= pairs;
    reports_taken   <= reports;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Top level of the block compare testbench. This module only makes stimulus
// and gives the verdict; a separate monitor watches both channels and the
// register port, predicts every report and compares it.
module tb;
  import bcc_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 5;
  // The back end fetches a job, delivers its reports, dispatches a block report
  // and waits for the shared remainder unit; the settle time is ample for all
  // of that after the last report.
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int OPENING_COUNT   = 14;

  // Opening pairs, packed as {end_of_data, good, suspect}. They hit the byte
  // extremes, equal and differing pairs, a block closed by its length, a
  // block closed early by end of data, a clean single-pair data set, and a
  // single pair that causes a mismatch, a block report and the totals at once.
  localparam logic [16:0] OPENING_PAIRS [OPENING_COUNT] = '{
    {1'b0, 8'h00, 8'hFF}, {1'b0, 8'hFF, 8'h00}, {1'b0, 8'h80, 8'h7F},
    {1'b0, 8'h00, 8'h00}, {1'b0, 8'hFF, 8'hFF}, {1'b0, 8'h55, 8'hAA},
    {1'b0, 8'h01, 8'h01}, {1'b0, 8'hFE, 8'hFE}, {1'b0, 8'h12, 8'h34},
    {1'b0, 8'h40, 8'h40}, {1'b0, 8'h05, 8'h06}, {1'b1, 8'h07, 8'h07},
    {1'b1, 8'h09, 8'h09}, {1'b1, 8'h3C, 8'hC3}
  };

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_good_byte;
  logic [7:0]  in_suspect_byte;
  logic        in_end_of_data;
  logic        empty;
  logic        pop;
  logic [1:0]  out_report_kind;
  logic [23:0] out_block_number;
  logic [7:0]  out_byte_position;
  logic [15:0] out_good_value;
  logic [15:0] out_suspect_value;
  logic [31:0] out_bad_byte_total;
  logic [23:0] out_bad_block_total;
  logic        out_last_report;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bit hold_req;
  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;
  int settings_written;
  int fault_count;
  int reports_pending;
  int pairs_taken;
  int reports_taken;

  block_compare_checksum DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_good_byte        (in_good_byte),
    .in_suspect_byte     (in_suspect_byte),
    .in_end_of_data      (in_end_of_data),
    .empty               (empty),
    .pop                 (pop),
    .out_report_kind     (out_report_kind),
    .out_block_number    (out_block_number),
    .out_byte_position   (out_byte_position),
    .out_good_value      (out_good_value),
    .out_suspect_value   (out_suspect_value),
    .out_bad_byte_total  (out_bad_byte_total),
    .out_bad_block_total (out_bad_block_total),
    .out_last_report     (out_last_report),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  bcc_report_checker u_report_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_good_byte        (in_good_byte),
    .in_suspect_byte     (in_suspect_byte),
    .in_end_of_data      (in_end_of_data),
    .empty               (empty),
    .pop                 (pop),
    .out_report_kind     (out_report_kind),
    .out_block_number    (out_block_number),
    .out_byte_position   (out_byte_position),
    .out_good_value      (out_good_value),
    .out_suspect_value   (out_suspect_value),
    .out_bad_byte_total  (out_bad_byte_total),
    .out_bad_block_total (out_bad_block_total),
    .out_last_report     (out_last_report),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .pready              (pready),
    .fault_count         (fault_count),
    .reports_pending     (reports_pending),
    .pairs_taken         (pairs_taken),
    .reports_taken       (reports_taken)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Watchdog: a hung handshake or a lost report ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side. Pop is drawn afresh every cycle from the stall rate of the
  // current phase. When the stimulus asks for a hold-off, pop stays low for
  // a long stretch so that the job queue fills and full rises while the
  // sender keeps offering pairs.
  initial begin
    pop = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      @(posedge clk);
    end
  end

  // Offers one pair and returns at the edge that takes it. Push is left high
  // so that a following pair can go out in the very next cycle; whoever comes
  // next either drives new data or lowers it.
  task automatic send_pair(input logic [7:0] g, input logic [7:0] s, input logic eod);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    in_good_byte    <= g;
    in_suspect_byte <= s;
    in_end_of_data  <= eod;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // A run of n pairs in which about mis_pct percent of the suspect bytes are
  // corrupted. When close is set the last pair marks the end of the data.
  task automatic send_record(input int n, input int mis_pct, input bit close);
    logic [7:0] g;
    for (int i = 0; i < n; i++) begin
      g = 8'($urandom);
      send_pair(g, ($urandom_range(0, 99) < mis_pct) ? g ^ 8'($urandom_range(1, 255)) : g,
                close && (i == n - 1));
    end
  endtask

  // Mostly well-formed data sets of random length, each with its own error
  // density. About one in six is left open, so the next set continues the
  // same data and blocks carry over phase boundaries and register changes.
  task automatic random_records(input int total, input int max_len, input int floor_pct);
    int left;
    int n;
    int pct;
    left = total;
    while (left > 0) begin
      n = $urandom_range(1, (max_len < left) ? max_len : left);
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 3;
        2:       pct = 25;
        default: pct = 70;
      endcase
      if (pct < floor_pct) pct = floor_pct;
      send_record(n, pct, $urandom_range(0, 5) != 0);
      left -= n;
    end
  endtask

  // Stops the sender, waits until every predicted report has been taken and
  // then gives the back end time to finish any work still in flight.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: a setup phase, then the access phase held until pready.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_written++;
  endtask

  task automatic set_phase(input int len, input int modulus, input int s_pct, input int r_pct);
    wait_idle();
    write_reg(REG_BLOCK_LENGTH, len);
    write_reg(REG_CHECK_MODULUS, modulus);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
  endtask

  initial begin
    rst_n           = 1'b0;
    push            = 1'b0;
    in_good_byte    = '0;
    in_suspect_byte = '0;
    in_end_of_data  = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Opening pairs with a block length below the minimum, which must act as
    // 10, and a modulus above 999, which is used as it stands.
    set_phase(0, 1023, 0, 0);
    for (int i = 0; i < OPENING_COUNT; i++)
      send_pair(OPENING_PAIRS[i][15:8], OPENING_PAIRS[i][7:0], OPENING_PAIRS[i][16]);

    // One block that sees the registers change while it is open: the first
    // pairs are folded into XOR parities, later ones into sums, and then the
    // length is set to 5, which acts as 10, so the block closes at 10.
    set_phase(255, 0, 0, 0);
    send_record(4, 100, 1'b0);
    wait_idle();
    write_reg(REG_CHECK_MODULUS, 999);
    send_record(4, 50, 1'b0);
    wait_idle();
    write_reg(REG_BLOCK_LENGTH, 5);
    send_record(3, 100, 1'b0);

    // Random phases. The first one runs without idling, starts with a long
    // receiver hold-off and carries many bad bytes, so the block must stall
    // its input.
    set_phase(10, 0, 0, 0);
    hold_req = 1'b1;
    random_records(50, 40, 30);

    set_phase(9, 1, 63, 0);
    random_records(40, 30, 0);

    // The longest block, closed once by its length and then by end of data.
    set_phase(255, 999, 0, 63);
    send_record(256, 10, 1'b1);

    set_phase($urandom_range(10, 40), 1023, 16, 16);
    random_records(40, 60, 0);

    set_phase($urandom_range(0, 255), $urandom_range(0, 1023), 0, 0);
    random_records(40, 60, 0);

    set_phase($urandom_range(10, 20), $urandom_range(2, 30), 0, 63);
    random_records(30, 30, 0);

    wait_idle();
    $display("Summary: %0d byte pairs taken and %0d reports checked after %0d register writes.",
             pairs_taken, reports_taken, settings_written);
    $display("Covered parity and modular sums, block lengths 10 to 255, and a full input stall.");
    if (fault_count == 0 && reports_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/bcc_pkg.sv
sv/bcc_front.sv
sv/bcc_fifo.sv
sv/bcc_div.sv
sv/bcc_back.sv
sv/block_compare_checksum.sv
tb/bcc_report_checker.sv
tb/tb.sv
